// ===== hw/rtl/ffpa_pkg.sv =====
// shared types and codes of the first-fit partition allocator
package ffpa_pkg;

  // default table sizes and address width
  localparam int FREE_ENTRIES_DEF = 16;
  localparam int PROC_ENTRIES_DEF = 16;
  localparam int ADDR_BITS_DEF    = 16;

  // request kinds
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_ALLOC   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
  localparam logic [1:0] STATUS_NO_NAME  = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  // controls broadcast to every free-table cell
  typedef struct packed {
    logic cmp;
    logic load;
    logic alloc;
    logic insert;
  } free_ctl_t;

  // controls broadcast to every process-table cell
  typedef struct packed {
    logic cmp;
    logic append;
    logic remove;
  } proc_ctl_t;

endpackage

// ===== hw/rtl/first_fit_partition_allocator.sv =====
// First-fit partition allocator: one request in, one result out. A request is
// taken, its table compare runs in every cell at once in the next cycle, and
// the update state, once the result register is free, resolves the first
// hit along the cell chain, updates both tables and writes the result
// register; a new request is taken in that same cycle.
// The free table and the process table are rows of FREE_ENTRIES and
// PROC_ENTRIES cells; entries stay packed at the front of each row, a retired
// block or removed process pulls the cells behind it up by one, and a
// released region is pushed in at the front of the free row.
module first_fit_partition_allocator import ffpa_pkg::*; #(
  parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
  parameter int PROC_ENTRIES = PROC_ENTRIES_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // proc_name, block_start, block_length
  input  logic [1:0]  s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // granted_start, granted_length
  output logic [1:0]  m_tuser   // status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [1:0]           req_kind;
  logic [7:0]           req_name;
  logic [ADDR_BITS-1:0] req_start;
  logic [ADDR_BITS-1:0] req_len;

  logic                 s_fire;
  logic                 out_free;
  logic                 upd_go;

  free_ctl_t            f_ctl;
  proc_ctl_t            p_ctl;

  logic                 f_valid   [FREE_ENTRIES];
  logic [ADDR_BITS-1:0] f_start   [FREE_ENTRIES];
  logic [ADDR_BITS-1:0] f_len     [FREE_ENTRIES];
  logic [ADDR_BITS-1:0] f_sel_s   [FREE_ENTRIES];
  logic                 f_taken   [FREE_ENTRIES+1];
  logic                 f_shift   [FREE_ENTRIES+1];

  logic                 p_valid   [PROC_ENTRIES];
  logic [7:0]           p_id      [PROC_ENTRIES];
  logic [ADDR_BITS-1:0] p_start   [PROC_ENTRIES];
  logic [ADDR_BITS-1:0] p_len     [PROC_ENTRIES];
  logic [ADDR_BITS-1:0] p_sel_s   [PROC_ENTRIES];
  logic [ADDR_BITS-1:0] p_sel_l   [PROC_ENTRIES];
  logic                 p_taken   [PROC_ENTRIES+1];

  logic [ADDR_BITS-1:0] fit_start;
  logic [ADDR_BITS-1:0] rel_start;
  logic [ADDR_BITS-1:0] rel_len;
  logic                 free_full;
  logic                 proc_full;
  logic                 free_found;
  logic                 proc_found;
  logic                 load_ok;
  logic                 alloc_ok;
  logic                 rel_ok;
  logic [1:0]           res_status;
  logic [ADDR_BITS-1:0] res_start;
  logic [ADDR_BITS-1:0] res_len;

  // handshake
  assign out_free = ~m_tvalid | m_tready;
  assign upd_go   = (state == ST_UPD) & out_free;
  assign s_tready = (state == ST_IDLE) | upd_go;
  assign s_fire   = s_tvalid & s_tready;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_fire) state_next = ST_CMP;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD:  if (upd_go) state_next = s_fire ? ST_CMP : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // request register
  always_ff @(posedge clk) begin
    if (s_fire) begin
      req_kind  <= s_tuser;
      req_name  <= s_tdata[7:0];
      req_start <= ADDR_BITS'(s_tdata[23:8]);
      req_len   <= ADDR_BITS'(s_tdata[39:24]);
    end
  end

  // gather the selected entries of both rows
  always_comb begin
    fit_start = '0;
    for (int i = 0; i < FREE_ENTRIES; i++) begin
      fit_start = fit_start | f_sel_s[i];
    end
  end

  always_comb begin
    rel_start = '0;
    rel_len   = '0;
    for (int i = 0; i < PROC_ENTRIES; i++) begin
      rel_start = rel_start | p_sel_s[i];
      rel_len   = rel_len | p_sel_l[i];
    end
  end

  // outcome of the request
  assign free_full  = f_valid[FREE_ENTRIES-1];
  assign proc_full  = p_valid[PROC_ENTRIES-1];
  assign free_found = f_taken[FREE_ENTRIES];
  assign proc_found = p_taken[PROC_ENTRIES];
  assign load_ok    = (req_kind == KIND_LOAD) & ~free_full;
  assign alloc_ok   = (req_kind == KIND_ALLOC) & ~proc_full & free_found;
  assign rel_ok     = (req_kind == KIND_RELEASE) & proc_found & ~free_full;

  always_comb begin
    res_status = STATUS_OK;
    res_start  = '0;
    res_len    = '0;
    unique case (req_kind)
      KIND_LOAD: begin
        if (free_full) begin
          res_status = STATUS_FULL;
        end else begin
          res_start = req_start;
          res_len   = req_len;
        end
      end
      KIND_ALLOC: begin
        if (proc_full) begin
          res_status = STATUS_FULL;
        end else if (!free_found) begin
          res_status = STATUS_NO_FIT;
        end else begin
          res_start = fit_start;
          res_len   = req_len;
        end
      end
      KIND_RELEASE: begin
        if (!proc_found) begin
          res_status = STATUS_NO_NAME;
        end else if (free_full) begin
          res_status = STATUS_FULL;
        end else begin
          res_start = rel_start;
          res_len   = rel_len;
        end
      end
      default: begin
        res_status = STATUS_OK;
      end
    endcase
  end

  // cell controls
  always_comb begin
    f_ctl.cmp    = (state == ST_CMP);
    f_ctl.load   = upd_go & load_ok;
    f_ctl.alloc  = upd_go & alloc_ok;
    f_ctl.insert = upd_go & rel_ok;
    p_ctl.cmp    = (state == ST_CMP);
    p_ctl.append = upd_go & alloc_ok;
    p_ctl.remove = upd_go & rel_ok;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (upd_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      m_tuser <= res_status;
      m_tdata <= {16'(res_len), 16'(res_start)};
    end
  end

  // free-block row
  assign f_taken[0] = 1'b0;
  assign f_shift[0] = 1'b0;

  for (genvar i = 0; i < FREE_ENTRIES; i++) begin : g_free
    logic                 lv;
    logic [ADDR_BITS-1:0] ls;
    logic [ADDR_BITS-1:0] ll;
    logic                 rv;
    logic [ADDR_BITS-1:0] rs;
    logic [ADDR_BITS-1:0] rl;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign ls = rel_start;
      assign ll = rel_len;
    end else begin : g_body
      assign lv = f_valid[i-1];
      assign ls = f_start[i-1];
      assign ll = f_len[i-1];
    end

    if (i == FREE_ENTRIES - 1) begin : g_tail
      assign rv = 1'b0;
      assign rs = '0;
      assign rl = '0;
    end else begin : g_inner
      assign rv = f_valid[i+1];
      assign rs = f_start[i+1];
      assign rl = f_len[i+1];
    end

    ffpa_free_cell #(
      .ADDR_BITS(ADDR_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (f_ctl),
      .req_len    (req_len),
      .load_start (req_start),
      .load_len   (req_len),
      .left_valid (lv),
      .left_start (ls),
      .left_len   (ll),
      .right_valid(rv),
      .right_start(rs),
      .right_len  (rl),
      .taken_in   (f_taken[i]),
      .shift_in   (f_shift[i]),
      .valid      (f_valid[i]),
      .start      (f_start[i]),
      .len        (f_len[i]),
      .taken_out  (f_taken[i+1]),
      .shift_out  (f_shift[i+1]),
      .sel_start  (f_sel_s[i])
    );
  end

  // process row
  assign p_taken[0] = 1'b0;

  for (genvar i = 0; i < PROC_ENTRIES; i++) begin : g_proc
    logic                 lv;
    logic                 rv;
    logic [7:0]           rid;
    logic [ADDR_BITS-1:0] rs;
    logic [ADDR_BITS-1:0] rl;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
    end else begin : g_body
      assign lv = p_valid[i-1];
    end

    if (i == PROC_ENTRIES - 1) begin : g_tail
      assign rv  = 1'b0;
      assign rid = '0;
      assign rs  = '0;
      assign rl  = '0;
    end else begin : g_inner
      assign rv  = p_valid[i+1];
      assign rid = p_id[i+1];
      assign rs  = p_start[i+1];
      assign rl  = p_len[i+1];
    end

    ffpa_proc_cell #(
      .ADDR_BITS(ADDR_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (p_ctl),
      .req_name   (req_name),
      .app_start  (fit_start),
      .app_len    (req_len),
      .left_valid (lv),
      .right_valid(rv),
      .right_id   (rid),
      .right_start(rs),
      .right_len  (rl),
      .taken_in   (p_taken[i]),
      .valid      (p_valid[i]),
      .id         (p_id[i]),
      .start      (p_start[i]),
      .len        (p_len[i]),
      .taken_out  (p_taken[i+1]),
      .sel_start  (p_sel_s[i]),
      .sel_len    (p_sel_l[i])
    );
  end

endmodule

// ===== hw/rtl/ffpa_free_cell.sv =====
// one entry of the free-block table, linked to its neighbors
module ffpa_free_cell import ffpa_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  free_ctl_t            ctl,
  input  logic [ADDR_BITS-1:0] req_len,
  input  logic [ADDR_BITS-1:0] load_start,
  input  logic [ADDR_BITS-1:0] load_len,
  input  logic                 left_valid,
  input  logic [ADDR_BITS-1:0] left_start,
  input  logic [ADDR_BITS-1:0] left_len,
  input  logic                 right_valid,
  input  logic [ADDR_BITS-1:0] right_start,
  input  logic [ADDR_BITS-1:0] right_len,
  input  logic                 taken_in,
  input  logic                 shift_in,
  output logic                 valid,
  output logic [ADDR_BITS-1:0] start,
  output logic [ADDR_BITS-1:0] len,
  output logic                 taken_out,
  output logic                 shift_out,
  output logic [ADDR_BITS-1:0] sel_start
);

  logic                 hit;
  logic                 first;
  logic [ADDR_BITS-1:0] rem;

  // first-fit chain: the first cell with a hit owns the request
  assign rem       = len - req_len;
  assign first     = hit & ~taken_in;
  assign taken_out = taken_in | hit;
  // a block used up entirely is retired, cells behind it move up
  assign shift_out = shift_in | (first & (rem == '0));
  assign sel_start = first ? start : '0;

  // valid and compare result
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctl.cmp) begin
        hit <= valid & (len >= req_len);
      end
      if (ctl.load) begin
        if (!valid && left_valid) valid <= 1'b1;
      end else if (ctl.alloc) begin
        if (shift_out) valid <= right_valid;
      end else if (ctl.insert) begin
        valid <= left_valid;
      end
    end
  end

  // block start and length
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (!valid && left_valid) begin
        start <= load_start;
        len   <= load_len;
      end
    end else if (ctl.alloc) begin
      if (shift_out) begin
        start <= right_start;
        len   <= right_len;
      end else if (first) begin
        start <= start + req_len;
        len   <= rem;
      end
    end else if (ctl.insert) begin
      start <= left_start;
      len   <= left_len;
    end
  end

endmodule

// ===== hw/rtl/ffpa_proc_cell.sv =====
// one entry of the process table, linked to its neighbors
module ffpa_proc_cell import ffpa_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  proc_ctl_t            ctl,
  input  logic [7:0]           req_name,
  input  logic [ADDR_BITS-1:0] app_start,
  input  logic [ADDR_BITS-1:0] app_len,
  input  logic                 left_valid,
  input  logic                 right_valid,
  input  logic [7:0]           right_id,
  input  logic [ADDR_BITS-1:0] right_start,
  input  logic [ADDR_BITS-1:0] right_len,
  input  logic                 taken_in,
  output logic                 valid,
  output logic [7:0]           id,
  output logic [ADDR_BITS-1:0] start,
  output logic [ADDR_BITS-1:0] len,
  output logic                 taken_out,
  output logic [ADDR_BITS-1:0] sel_start,
  output logic [ADDR_BITS-1:0] sel_len
);

  logic hit;
  logic first;

  // oldest matching process owns the release
  assign first     = hit & ~taken_in;
  assign taken_out = taken_in | hit;
  assign sel_start = first ? start : '0;
  assign sel_len   = first ? len : '0;

  // valid and name match
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctl.cmp) begin
        hit <= valid & (id == req_name);
      end
      if (ctl.append) begin
        if (!valid && left_valid) valid <= 1'b1;
      end else if (ctl.remove) begin
        if (taken_out) valid <= right_valid;
      end
    end
  end

  // process name and region
  always_ff @(posedge clk) begin
    if (ctl.append) begin
      if (!valid && left_valid) begin
        id    <= req_name;
        start <= app_start;
        len   <= app_len;
      end
    end else if (ctl.remove) begin
      if (taken_out) begin
        id    <= right_id;
        start <= right_start;
        len   <= right_len;
      end
    end
  end

endmodule

// ===== hw/rtl/ffpa_checker.sv =====
// port-level checks of the first-fit partition allocator, bound to the top level
module ffpa_checker import ffpa_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  logic s_fire;
  assign s_fire = s_tvalid & s_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a failed request reports zero start and length
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STATUS_OK) |-> (m_tdata == 32'd0))
    else $error("failed request with nonzero region");

  // one request at a time: not ready in the cycle after a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !s_tready)
    else $error("request taken during table compare");

  // a taken request is later followed by a valid result
  a_result_due: assert property (@(posedge clk) disable iff (rst)
    s_fire |-> ##3 m_tvalid)
    else $error("no result after request");

endmodule

bind first_fit_partition_allocator ffpa_checker u_ffpa_checker (.*);

// ===== test/tb_first_fit_partition_allocator.sv =====
// self-checking testbench of the first-fit partition allocator
module tb_first_fit_partition_allocator;
  import ffpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int FREE_DEPTH  = FREE_ENTRIES_DEF;
  localparam int PROC_DEPTH  = PROC_ENTRIES_DEF;
  localparam int ITEM_TARGET = 2000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] grant_start;
    logic [15:0] grant_len;
  } grant_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  name;
    logic [15:0] blk_start;
    logic [15:0] blk_len;
    bit          typed;
    grant_t      want;
  } plan_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // proc_name, block_start, block_length
  logic [1:0]  s_tuser = '0;  // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // granted_start, granted_length
  logic [1:0]  m_tuser;       // status

  // shadow of the free-block list and the process list
  logic [15:0] fb_start [FREE_DEPTH];
  logic [15:0] fb_len   [FREE_DEPTH];
  int          fb_count = 0;
  logic [7:0]  pr_id    [PROC_DEPTH];
  logic [15:0] pr_start [PROC_DEPTH];
  logic [15:0] pr_len   [PROC_DEPTH];
  int          pr_count = 0;

  grant_t    grant_q [$];
  plan_row_t plan_q  [$];
  int        issued = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 18;
  int        recv_stall_pct = 74;

  first_fit_partition_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run a request through the shadow lists and return the grant it yields
  task automatic predict_grant(input logic [1:0] kind, input logic [7:0] name,
                               input logic [15:0] bs, input logic [15:0] bl,
                               output grant_t g);
    int i;
    int k;
    logic [15:0] rem;
    g = '0;
    g.status = STATUS_OK;
    case (kind)
      KIND_LOAD: begin
        if (fb_count >= FREE_DEPTH) begin
          g.status = STATUS_FULL;
        end else begin
          fb_start[fb_count] = bs;
          fb_len[fb_count] = bl;
          fb_count++;
          g.grant_start = bs;
          g.grant_len = bl;
        end
      end
      KIND_ALLOC: begin
        if (pr_count >= PROC_DEPTH) begin
          g.status = STATUS_FULL;
        end else begin
          i = 0;
          while (i < fb_count && fb_len[i] < bl) i++;
          if (i >= fb_count) begin
            g.status = STATUS_NO_FIT;
          end else begin
            g.grant_start = fb_start[i];
            g.grant_len = bl;
            rem = fb_len[i] - bl;
            // an exhausted block is retired and the rest move up
            if (rem == 16'd0) begin
              for (k = i; k + 1 < fb_count; k++) begin
                fb_start[k] = fb_start[k + 1];
                fb_len[k] = fb_len[k + 1];
              end
              fb_count--;
            end else begin
              fb_start[i] = fb_start[i] + bl;
              fb_len[i] = rem;
            end
            pr_id[pr_count] = name;
            pr_start[pr_count] = g.grant_start;
            pr_len[pr_count] = bl;
            pr_count++;
          end
        end
      end
      KIND_RELEASE: begin
        i = 0;
        while (i < pr_count && pr_id[i] != name) i++;
        if (i >= pr_count) begin
          g.status = STATUS_NO_NAME;
        end else if (fb_count >= FREE_DEPTH) begin
          g.status = STATUS_FULL;
        end else begin
          // region goes to the front of the free list, no merging
          for (k = fb_count; k > 0; k--) begin
            fb_start[k] = fb_start[k - 1];
            fb_len[k] = fb_len[k - 1];
          end
          fb_start[0] = pr_start[i];
          fb_len[0] = pr_len[i];
          fb_count++;
          g.grant_start = pr_start[i];
          g.grant_len = pr_len[i];
          for (k = i; k + 1 < pr_count; k++) begin
            pr_id[k] = pr_id[k + 1];
            pr_start[k] = pr_start[k + 1];
            pr_len[k] = pr_len[k + 1];
          end
          pr_count--;
        end
      end
      default: begin
      end
    endcase
  endtask

  // present one request, wait for acceptance, then record its grant
  task automatic issue(input logic [1:0] kind, input logic [7:0] name,
                       input logic [15:0] bs, input logic [15:0] bl,
                       input bit typed, input grant_t want);
    grant_t g;
    // idle pattern by third of the run: receiver stalls, then sender idles, then none
    if (issued < ITEM_TARGET / 3) begin
      send_idle_pct = 18;
      recv_stall_pct = 74;
    end else if (issued < 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 74;
      recv_stall_pct = 18;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {bl, bs, name};
    s_tuser <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_grant(kind, name, bs, bl, g);
    grant_q.push_back(typed ? want : g);
    issued++;
  endtask

  task automatic add_row(input logic [1:0] kind, input logic [7:0] name,
                         input logic [15:0] bs, input logic [15:0] bl,
                         input bit typed, input logic [1:0] st,
                         input logic [15:0] gs, input logic [15:0] gl);
    plan_row_t r;
    r.kind = kind;
    r.name = name;
    r.blk_start = bs;
    r.blk_len = bl;
    r.typed = typed;
    r.want = '{status: st, grant_start: gs, grant_len: gl};
    plan_q.push_back(r);
  endtask

  // one random request of a given flavor, shaped by the shadow lists
  // flavors: 0 load, 1 allocate, 2 release, 3 zero-size allocate, else unused kind
  task automatic random_request(input int flavor);
    logic [1:0]  kind;
    logic [7:0]  name;
    logic [15:0] bs;
    logic [15:0] bl;
    int pick;
    name = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    bs = 16'($urandom);
    bl = 16'($urandom);
    pick = $urandom_range(0, 99);
    case (flavor)
      0: begin
        kind = KIND_LOAD;
        if (pick < 50) bl = 16'($urandom_range(16, 4096));
        else if (pick < 65) bl = 16'($urandom_range(0, 16));
        else if (pick < 75) bl = 16'd0;
      end
      1: begin
        kind = KIND_ALLOC;
        if (pick < 40 && fb_count > 0) bl = fb_len[$urandom_range(0, fb_count - 1)];
        else if (pick < 75) bl = 16'($urandom_range(1, 64));
        else if (pick < 85) bl = 16'd0;
      end
      2: begin
        kind = KIND_RELEASE;
        if (pick < 75 && pr_count > 0) name = pr_id[$urandom_range(0, pr_count - 1)];
      end
      3: begin
        kind = KIND_ALLOC;
        bl = 16'd0;
      end
      default: begin
        kind = KIND_UNUSED;
      end
    endcase
    issue(kind, name, bs, bl, 1'b0, '0);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // compare each grant with the oldest expectation
  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{status: m_tuser, grant_start: m_tdata[15:0], grant_len: m_tdata[31:16]};
      if (grant_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("mismatch: unexpected grant status %0d start %h len %h",
                   got.status, got.grant_start, got.grant_len);
      end else begin
        want = grant_q.pop_front();
        if (got.status !== want.status || got.grant_start !== want.grant_start ||
            got.grant_len !== want.grant_len) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch: exp status %0d start %h len %h, got %0d %h %h",
                     want.status, want.grant_start, want.grant_len,
                     got.status, got.grant_start, got.grant_len);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int pick;
    // directed requests; expected grant typed in where obvious
    add_row(KIND_RELEASE, 8'h05, 16'h0000, 16'h0000, 1'b1, STATUS_NO_NAME, 16'h0, 16'h0);
    add_row(KIND_ALLOC,   8'h01, 16'h0000, 16'h0000, 1'b1, STATUS_NO_FIT, 16'h0, 16'h0);
    add_row(KIND_UNUSED,  8'hff, 16'hffff, 16'hffff, 1'b1, STATUS_OK, 16'h0, 16'h0);
    add_row(KIND_LOAD,    8'h00, 16'hfff0, 16'h0020, 1'b1, STATUS_OK, 16'hfff0, 16'h0020);
    add_row(KIND_LOAD,    8'h00, 16'h0000, 16'hffff, 1'b1, STATUS_OK, 16'h0000, 16'hffff);
    add_row(KIND_LOAD,    8'h00, 16'h1234, 16'h0000, 1'b1, STATUS_OK, 16'h1234, 16'h0000);
    // address wraps past the top of the space
    add_row(KIND_ALLOC,   8'hff, 16'h0000, 16'h0018, 1'b0, STATUS_OK, 16'h0, 16'h0);
    add_row(KIND_ALLOC,   8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK, 16'h0, 16'h0);
    add_row(KIND_ALLOC,   8'haa, 16'h0000, 16'hffff, 1'b0, STATUS_OK, 16'h0, 16'h0);
    add_row(KIND_ALLOC,   8'haa, 16'h0000, 16'h0009, 1'b1, STATUS_NO_FIT, 16'h0, 16'h0);
    // duplicate names, exact fit and zero-size block retirement
    add_row(KIND_ALLOC,   8'h10, 16'h0000, 16'h0000, 1'b0, STATUS_OK, 16'h0, 16'h0);
    add_row(KIND_ALLOC,   8'h10, 16'h0000, 16'h0008, 1'b0, STATUS_OK, 16'h0, 16'h0);
    add_row(KIND_ALLOC,   8'h10, 16'h0000, 16'h0000, 1'b0, STATUS_OK, 16'h0, 16'h0);
    add_row(KIND_RELEASE, 8'haa, 16'h0000, 16'h0000, 1'b0, STATUS_OK, 16'h0, 16'h0);
    add_row(KIND_RELEASE, 8'h10, 16'h0000, 16'h0000, 1'b0, STATUS_OK, 16'h0, 16'h0);
    add_row(KIND_RELEASE, 8'h77, 16'h0000, 16'h0000, 1'b1, STATUS_NO_NAME, 16'h0, 16'h0);
    add_row(KIND_LOAD,    8'h00, 16'hffff, 16'hffff, 1'b1, STATUS_OK, 16'hffff, 16'hffff);
    add_row(KIND_ALLOC,   8'h55, 16'h0000, 16'hffff, 1'b0, STATUS_OK, 16'h0, 16'h0);
    add_row(KIND_RELEASE, 8'hff, 16'h0000, 16'h0000, 1'b0, STATUS_OK, 16'h0, 16'h0);
    add_row(KIND_RELEASE, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK, 16'h0, 16'h0);
    add_row(KIND_UNUSED,  8'h00, 16'h0000, 16'h0000, 1'b1, STATUS_OK, 16'h0, 16'h0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_q[i]) begin
      issue(plan_q[i].kind, plan_q[i].name, plan_q[i].blk_start, plan_q[i].blk_len,
            plan_q[i].typed, plan_q[i].want);
    end

    // random mix; bursts drive both lists to full and drain them again
    while (issued < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) repeat ($urandom_range(8, 18)) random_request(0);
      else if (pick < 8) repeat (PROC_DEPTH + 1) random_request(3);
      else if (pick < 11) repeat ($urandom_range(4, 16)) random_request(2);
      else if (pick < 38) random_request(0);
      else if (pick < 70) random_request(1);
      else if (pick < 95) random_request(2);
      else random_request(4);
    end
    s_tvalid <= 1'b0;

    // drain outstanding grants, then watch for strays
    while (grant_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
